// ===== rtl/ufp_pkg.sv =====
`default_nettype none

package ufp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] CLASS_RXM   = 8'h02;
  localparam logic [7:0] ID_RAWX     = 8'h15;
  localparam logic [7:0] ID_SFRBX    = 8'h13;

  localparam int unsigned TOTAL_WIDTH = 32;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_HEAD  = 3'd2,
    PH_PAY   = 3'd3,
    PH_CKA   = 3'd4,
    PH_CKB   = 3'd5
  } phase_e;

endpackage

`default_nettype wire

// ===== rtl/ubx_frame_parser_counter.sv =====
// UBX frame parser: takes one received byte per beat and tracks sync, header, payload
// and the two 8-bit Fletcher checksum bytes, without storing the payload. Each accepted
// byte gives exactly one result beat in the next cycle, from a result register; a byte
// can be accepted every cycle, and the input stalls only while a result is held by a
// stall on the output. Results show the parser state after the byte: frame_end_o and
// frame_valid_o on the second checksum byte, the class, id and length of the current or
// last frame, and saturating counts of valid RXM-RAWX, valid RXM-SFRBX and bad frames.
// Counters are COUNT_WIDTH bits wide; the 32-bit totals clip at all ones when wider.
`default_nettype none

module ubx_frame_parser_counter #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic             frame_end_o,
  output logic             frame_valid_o,
  output logic [7:0]       message_class_o,
  output logic [7:0]       message_id_o,
  output logic [15:0]      payload_length_o,
  output logic             is_raw_measurement_o,
  output logic             is_nav_subframe_o,
  output logic             hunting_o,
  output logic [31:0]      raw_total_o,
  output logic [31:0]      subframe_total_o,
  output logic [31:0]      bad_total_o
);

  localparam int unsigned TW = ufp_pkg::TOTAL_WIDTH;

  ufp_pkg::phase_e phase_q, phase_d;
  logic [1:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  rx_a_q, rx_a_d;
  logic [COUNT_WIDTH-1:0] raw_cnt_q, raw_cnt_d;
  logic [COUNT_WIDTH-1:0] sub_cnt_q, sub_cnt_d;
  logic [COUNT_WIDTH-1:0] bad_cnt_q, bad_cnt_d;

  logic end_d, good_d, raw_d, nav_d;
  logic [TW-1:0] raw_tot_d, sub_tot_d, bad_tot_d;
  logic [7:0] add_a;
  logic accept;

  logic        valid_q;
  logic        end_q, good_q, raw_q, nav_q, hunt_q;
  logic [7:0]  oclass_q, oid_q;
  logic [15:0] olen_q;
  logic [TW-1:0] raw_tot_q, sub_tot_q, bad_tot_q;

  assign stall_o = valid_q & stall_i;
  assign accept  = valid_i & ~stall_o;
  assign add_a   = sum_a_q + rx_byte_i;

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    class_d   = class_q;
    id_d      = id_q;
    len_d     = len_q;
    seen_d    = seen_q;
    sum_a_d   = sum_a_q;
    sum_b_d   = sum_b_q;
    rx_a_d    = rx_a_q;
    raw_cnt_d = raw_cnt_q;
    sub_cnt_d = sub_cnt_q;
    bad_cnt_d = bad_cnt_q;
    end_d     = 1'b0;
    good_d    = 1'b0;
    raw_d     = 1'b0;
    nav_d     = 1'b0;
    case (phase_q)
      ufp_pkg::PH_SYNC2: begin
        phase_d   = (rx_byte_i == ufp_pkg::SYNC_SECOND) ? ufp_pkg::PH_HEAD : ufp_pkg::PH_HUNT;
        hdr_idx_d = 2'd0;
        seen_d    = 16'd0;
        sum_a_d   = 8'd0;
        sum_b_d   = 8'd0;
      end
      ufp_pkg::PH_HEAD: begin
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
        case (hdr_idx_q)
          2'd0:    class_d = rx_byte_i;
          2'd1:    id_d    = rx_byte_i;
          2'd2:    len_d   = {8'd0, rx_byte_i};
          default: len_d   = {rx_byte_i, len_q[7:0]};
        endcase
        hdr_idx_d = hdr_idx_q + 2'd1;
        if (hdr_idx_q == 2'd3) begin
          phase_d = ({rx_byte_i, len_q[7:0]} == 16'd0) ? ufp_pkg::PH_CKA : ufp_pkg::PH_PAY;
        end
      end
      ufp_pkg::PH_PAY: begin
        sum_a_d = add_a;
        sum_b_d = sum_b_q + add_a;
        seen_d  = seen_q + 16'd1;
        if (seen_d == len_q) begin
          phase_d = ufp_pkg::PH_CKA;
        end
      end
      ufp_pkg::PH_CKA: begin
        rx_a_d  = rx_byte_i;
        phase_d = ufp_pkg::PH_CKB;
      end
      ufp_pkg::PH_CKB: begin
        end_d   = 1'b1;
        good_d  = (rx_a_q == sum_a_q) && (rx_byte_i == sum_b_q);
        phase_d = ufp_pkg::PH_HUNT;
        if (good_d) begin
          if (class_q == ufp_pkg::CLASS_RXM && id_q == ufp_pkg::ID_RAWX) begin
            raw_d     = 1'b1;
            raw_cnt_d = (&raw_cnt_q) ? raw_cnt_q : raw_cnt_q + 1'b1;
          end else if (class_q == ufp_pkg::CLASS_RXM && id_q == ufp_pkg::ID_SFRBX) begin
            nav_d     = 1'b1;
            sub_cnt_d = (&sub_cnt_q) ? sub_cnt_q : sub_cnt_q + 1'b1;
          end
        end else begin
          bad_cnt_d = (&bad_cnt_q) ? bad_cnt_q : bad_cnt_q + 1'b1;
        end
      end
      default: begin
        phase_d = (rx_byte_i == ufp_pkg::SYNC_FIRST) ? ufp_pkg::PH_SYNC2 : ufp_pkg::PH_HUNT;
      end
    endcase
  end

  // clip wide counters to the 32-bit totals
  if (COUNT_WIDTH > TW) begin : g_clip
    assign raw_tot_d = (|raw_cnt_d[COUNT_WIDTH-1:TW]) ? '1 : raw_cnt_d[TW-1:0];
    assign sub_tot_d = (|sub_cnt_d[COUNT_WIDTH-1:TW]) ? '1 : sub_cnt_d[TW-1:0];
    assign bad_tot_d = (|bad_cnt_d[COUNT_WIDTH-1:TW]) ? '1 : bad_cnt_d[TW-1:0];
  end else begin : g_ext
    assign raw_tot_d = TW'(raw_cnt_d);
    assign sub_tot_d = TW'(sub_cnt_d);
    assign bad_tot_d = TW'(bad_cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ufp_pkg::PH_HUNT;
      hdr_idx_q <= 2'd0;
      class_q   <= 8'd0;
      id_q      <= 8'd0;
      len_q     <= 16'd0;
      seen_q    <= 16'd0;
      sum_a_q   <= 8'd0;
      sum_b_q   <= 8'd0;
      rx_a_q    <= 8'd0;
      raw_cnt_q <= '0;
      sub_cnt_q <= '0;
      bad_cnt_q <= '0;
    end else if (accept) begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      class_q   <= class_d;
      id_q      <= id_d;
      len_q     <= len_d;
      seen_q    <= seen_d;
      sum_a_q   <= sum_a_d;
      sum_b_q   <= sum_b_d;
      rx_a_q    <= rx_a_d;
      raw_cnt_q <= raw_cnt_d;
      sub_cnt_q <= sub_cnt_d;
      bad_cnt_q <= bad_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      end_q     <= end_d;
      good_q    <= good_d;
      raw_q     <= raw_d;
      nav_q     <= nav_d;
      hunt_q    <= (phase_d == ufp_pkg::PH_HUNT);
      oclass_q  <= class_d;
      oid_q     <= id_d;
      olen_q    <= len_d;
      raw_tot_q <= raw_tot_d;
      sub_tot_q <= sub_tot_d;
      bad_tot_q <= bad_tot_d;
    end
  end

  assign valid_o              = valid_q;
  assign frame_end_o          = end_q;
  assign frame_valid_o        = good_q;
  assign message_class_o      = oclass_q;
  assign message_id_o         = oid_q;
  assign payload_length_o     = olen_q;
  assign is_raw_measurement_o = raw_q;
  assign is_nav_subframe_o    = nav_q;
  assign hunting_o            = hunt_q;
  assign raw_total_o          = raw_tot_q;
  assign subframe_total_o     = sub_tot_q;
  assign bad_total_o          = bad_tot_q;

endmodule

`default_nettype wire

// ===== rtl/ufp_checker.sv =====
`default_nettype none

module ufp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic        frame_end_o,
  input wire logic        frame_valid_o,
  input wire logic [7:0]  message_class_o,
  input wire logic [7:0]  message_id_o,
  input wire logic        is_raw_measurement_o,
  input wire logic        is_nav_subframe_o,
  input wire logic        hunting_o,
  input wire logic [31:0] raw_total_o
);

  // a good frame is always a finished one
  a_valid_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && frame_valid_o |-> frame_end_o)
    else $error("frame_valid without frame_end");

  a_raw_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_raw_measurement_o |->
      frame_valid_o && message_class_o == ufp_pkg::CLASS_RXM
      && message_id_o == ufp_pkg::ID_RAWX)
    else $error("raw flag on wrong frame");

  a_nav_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_nav_subframe_o |->
      frame_valid_o && message_class_o == ufp_pkg::CLASS_RXM
      && message_id_o == ufp_pkg::ID_SFRBX)
    else $error("subframe flag on wrong frame");

  // after the last checksum byte the parser is back to hunting
  a_end_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && frame_end_o |-> hunting_o)
    else $error("frame end without hunt");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(raw_total_o))
    else $error("stalled beat changed");

endmodule

bind ubx_frame_parser_counter ufp_checker u_ufp_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .valid_o              (valid_o),
  .stall_i              (stall_i),
  .frame_end_o          (frame_end_o),
  .frame_valid_o        (frame_valid_o),
  .message_class_o      (message_class_o),
  .message_id_o         (message_id_o),
  .is_raw_measurement_o (is_raw_measurement_o),
  .is_nav_subframe_o    (is_nav_subframe_o),
  .hunting_o            (hunting_o),
  .raw_total_o          (raw_total_o)
);

`default_nettype wire

// ===== dv/ubx_frame_parser_counter_checker.sv =====
`timescale 1ns / 100ps

module ubx_frame_parser_counter_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  logic              byte_stall_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              res_valid_i,
  input  logic              res_stall_i,
  input  logic              frame_end_i,
  input  logic              frame_valid_i,
  input  logic [7:0]        message_class_i,
  input  logic [7:0]        message_id_i,
  input  logic [15:0]       payload_length_i,
  input  logic              is_raw_measurement_i,
  input  logic              is_nav_subframe_i,
  input  logic              hunting_i,
  input  logic [31:0]       raw_total_i,
  input  logic [31:0]       subframe_total_i,
  input  logic [31:0]       bad_total_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic        frame_end;
    logic        frame_valid;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] length;
    logic        raw;
    logic        subframe;
    logic        hunting;
    logic [31:0] raw_total;
    logic [31:0] subframe_total;
    logic [31:0] bad_total;
  } parse_result_t;

  ufp_pkg::phase_e                 ph;
  logic [1:0]                      hdr_idx;
  logic [7:0]                      frm_class;
  logic [7:0]                      frm_id;
  logic [15:0]                     frm_len;
  logic [15:0]                     pay_count;
  logic [7:0]                      sum_a;
  logic [7:0]                      sum_b;
  logic [7:0]                      got_ck_a;
  logic [ufp_pkg::TOTAL_WIDTH-1:0] raw_cnt;
  logic [ufp_pkg::TOTAL_WIDTH-1:0] sfrbx_cnt;
  logic [ufp_pkg::TOTAL_WIDTH-1:0] bad_cnt;
  parse_result_t                   predicted_results[$];

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  function automatic void add_to_sums(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  function automatic parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t r;
    r = '0;
    case (ph)
      ufp_pkg::PH_SYNC2: begin
        ph = (b == ufp_pkg::SYNC_SECOND) ? ufp_pkg::PH_HEAD : ufp_pkg::PH_HUNT;
        hdr_idx = '0;
        pay_count = '0;
        sum_a = '0;
        sum_b = '0;
      end
      ufp_pkg::PH_HEAD: begin
        add_to_sums(b);
        case (hdr_idx)
          2'd0: frm_class = b;
          2'd1: frm_id = b;
          2'd2: frm_len = {8'h00, b};
          default: frm_len = frm_len | {b, 8'h00};
        endcase
        if (hdr_idx == 2'd3) begin
          hdr_idx = '0;
          ph = (frm_len == 16'd0) ? ufp_pkg::PH_CKA : ufp_pkg::PH_PAY;
        end else begin
          hdr_idx = hdr_idx + 2'd1;
        end
      end
      ufp_pkg::PH_PAY: begin
        add_to_sums(b);
        pay_count = pay_count + 16'd1;
        if (pay_count == frm_len) begin
          ph = ufp_pkg::PH_CKA;
        end
      end
      ufp_pkg::PH_CKA: begin
        got_ck_a = b;
        ph = ufp_pkg::PH_CKB;
      end
      ufp_pkg::PH_CKB: begin
        r.frame_end = 1'b1;
        r.frame_valid = (got_ck_a == sum_a) && (b == sum_b);
        if (r.frame_valid) begin
          if (frm_class == ufp_pkg::CLASS_RXM && frm_id == ufp_pkg::ID_RAWX) begin
            r.raw = 1'b1;
            if (raw_cnt != '1) raw_cnt++;
          end else if (frm_class == ufp_pkg::CLASS_RXM && frm_id == ufp_pkg::ID_SFRBX) begin
            r.subframe = 1'b1;
            if (sfrbx_cnt != '1) sfrbx_cnt++;
          end
        end else begin
          if (bad_cnt != '1) bad_cnt++;
        end
        ph = ufp_pkg::PH_HUNT;
      end
      default: begin
        ph = (b == ufp_pkg::SYNC_FIRST) ? ufp_pkg::PH_SYNC2 : ufp_pkg::PH_HUNT;
      end
    endcase
    r.msg_class = frm_class;
    r.msg_id = frm_id;
    r.length = frm_len;
    r.hunting = (ph == ufp_pkg::PH_HUNT) || (ph > ufp_pkg::PH_CKB);
    r.raw_total = raw_cnt;
    r.subframe_total = sfrbx_cnt;
    r.bad_total = bad_cnt;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t want;
    if (!rst_ni) begin
      ph = ufp_pkg::PH_HUNT;
      hdr_idx = '0;
      frm_class = '0;
      frm_id = '0;
      frm_len = '0;
      pay_count = '0;
      sum_a = '0;
      sum_b = '0;
      got_ck_a = '0;
      raw_cnt = '0;
      sfrbx_cnt = '0;
      bad_cnt = '0;
      predicted_results.delete();
      pending_o <= 0;
    end else begin
      if (byte_valid_i && !byte_stall_i) begin
        predicted_results.insert(predicted_results.size(), parse_byte(rx_byte_i));
      end
      if (res_valid_i && !res_stall_i) begin
        if (predicted_results.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = predicted_results.pop_front();
          check_field("frame_end", 32'(frame_end_i), 32'(want.frame_end));
          check_field("frame_valid", 32'(frame_valid_i), 32'(want.frame_valid));
          check_field("message_class", 32'(message_class_i), 32'(want.msg_class));
          check_field("message_id", 32'(message_id_i), 32'(want.msg_id));
          check_field("payload_length", 32'(payload_length_i), 32'(want.length));
          check_field("is_raw_measurement", 32'(is_raw_measurement_i), 32'(want.raw));
          check_field("is_nav_subframe", 32'(is_nav_subframe_i), 32'(want.subframe));
          check_field("hunting", 32'(hunting_i), 32'(want.hunting));
          check_field("raw_total", raw_total_i, want.raw_total);
          check_field("subframe_total", subframe_total_i, want.subframe_total);
          check_field("bad_total", bad_total_i, want.bad_total);
        end
      end
      pending_o <= predicted_results.size();
    end
  end

  initial begin
    errors_o = 0;
  end

endmodule

// ===== dv/tb_ubx_frame_parser_counter.sv =====
`timescale 1ns / 100ps

module tb_ubx_frame_parser_counter;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PHASE_BEATS = 230;

  typedef enum int unsigned {
    DMG_NONE,
    DMG_CK_A,
    DMG_CK_B,
    DMG_PAYLOAD
  } damage_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic        frame_end_o;
  logic        frame_valid_o;
  logic [7:0]  message_class_o;
  logic [7:0]  message_id_o;
  logic [15:0] payload_length_o;
  logic        is_raw_measurement_o;
  logic        is_nav_subframe_o;
  logic        hunting_o;
  logic [31:0] raw_total_o;
  logic [31:0] subframe_total_o;
  logic [31:0] bad_total_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned sent_count = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  tx_bytes[$];

  always #1 clk_i = ~clk_i;

  ubx_frame_parser_counter dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .valid_i              (valid_i),
    .stall_o              (stall_o),
    .rx_byte_i            (rx_byte_i),
    .valid_o              (valid_o),
    .stall_i              (stall_i),
    .frame_end_o          (frame_end_o),
    .frame_valid_o        (frame_valid_o),
    .message_class_o      (message_class_o),
    .message_id_o         (message_id_o),
    .payload_length_o     (payload_length_o),
    .is_raw_measurement_o (is_raw_measurement_o),
    .is_nav_subframe_o    (is_nav_subframe_o),
    .hunting_o            (hunting_o),
    .raw_total_o          (raw_total_o),
    .subframe_total_o     (subframe_total_o),
    .bad_total_o          (bad_total_o)
  );

  ubx_frame_parser_counter_checker chk (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .byte_valid_i         (valid_i),
    .byte_stall_i         (stall_o),
    .rx_byte_i            (rx_byte_i),
    .res_valid_i          (valid_o),
    .res_stall_i          (stall_i),
    .frame_end_i          (frame_end_o),
    .frame_valid_i        (frame_valid_o),
    .message_class_i      (message_class_o),
    .message_id_i         (message_id_o),
    .payload_length_i     (payload_length_o),
    .is_raw_measurement_i (is_raw_measurement_o),
    .is_nav_subframe_i    (is_nav_subframe_o),
    .hunting_i            (hunting_o),
    .raw_total_i          (raw_total_o),
    .subframe_total_i     (subframe_total_o),
    .bad_total_i          (bad_total_o),
    .errors_o             (errors),
    .pending_o            (pending)
  );

  always @(negedge clk_i) begin
    stall_i <= rst_ni && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    tx_bytes.insert(tx_bytes.size(), b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      valid_i <= 1'b0;
      rx_byte_i <= 8'($urandom);
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    rx_byte_i <= b;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !stall_o;
      @(negedge clk_i);
    end
    sent_count++;
  endtask

  task automatic flush_bytes();
    while (tx_bytes.size() > 0) begin
      send_byte(tx_bytes.pop_front());
    end
  endtask

  task automatic add_frame(input logic [7:0] cls, input logic [7:0] id,
                           input int unsigned len, input damage_e dmg);
    logic [7:0]  body[$];
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    int unsigned k;
    body.insert(body.size(), cls);
    body.insert(body.size(), id);
    body.insert(body.size(), len[7:0]);
    body.insert(body.size(), len[15:8]);
    for (k = 0; k < len; k++) begin
      body.insert(body.size(), 8'($urandom));
    end
    ck_a = '0;
    ck_b = '0;
    foreach (body[i]) begin
      ck_a = ck_a + body[i];
      ck_b = ck_b + ck_a;
    end
    case (dmg)
      DMG_CK_A: ck_a ^= 8'($urandom_range(1, 255));
      DMG_CK_B: ck_b ^= 8'($urandom_range(1, 255));
      DMG_PAYLOAD: begin
        if (len == 0) begin
          ck_a ^= 8'($urandom_range(1, 255));
        end else begin
          k = $urandom_range(4, body.size() - 1);
          body[k] ^= 8'(1 << $urandom_range(0, 7));
        end
      end
      default: ;
    endcase
    queue_byte(ufp_pkg::SYNC_FIRST);
    queue_byte(ufp_pkg::SYNC_SECOND);
    foreach (body[i]) queue_byte(body[i]);
    queue_byte(ck_a);
    queue_byte(ck_b);
  endtask

  task automatic add_random_frame(input damage_e dmg);
    logic [7:0]  cls;
    logic [7:0]  id;
    int unsigned len;
    int unsigned pick;
    case ($urandom_range(0, 3))
      0: begin
        cls = ufp_pkg::CLASS_RXM;
        id = ufp_pkg::ID_RAWX;
      end
      1: begin
        cls = ufp_pkg::CLASS_RXM;
        id = ufp_pkg::ID_SFRBX;
      end
      2: begin
        cls = ufp_pkg::CLASS_RXM;
        id = 8'($urandom);
      end
      default: begin
        cls = 8'($urandom);
        id = 8'($urandom);
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 80) len = $urandom_range(0, 8);
    else if (pick < 97) len = $urandom_range(9, 40);
    else len = $urandom_range(256, 300);
    add_frame(cls, id, len, dmg);
  endtask

  // header with a short payload and no checksum, the next bytes get swallowed
  task automatic add_cut_frame();
    int unsigned len;
    int unsigned k;
    len = $urandom_range(1, 20);
    queue_byte(ufp_pkg::SYNC_FIRST);
    queue_byte(ufp_pkg::SYNC_SECOND);
    queue_byte(8'($urandom));
    queue_byte(8'($urandom));
    queue_byte(8'(len));
    queue_byte(8'h00);
    for (k = $urandom_range(0, len - 1); k > 0; k--) begin
      queue_byte(8'($urandom));
    end
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall);
    int unsigned goal;
    int unsigned pick;
    logic [7:0]  b;
    idle_pct = idle;
    stall_pct = stall;
    goal = sent_count + PHASE_BEATS;
    while (sent_count < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        add_random_frame(DMG_NONE);
      end else if (pick < 75) begin
        add_random_frame(damage_e'($urandom_range(DMG_CK_A, DMG_PAYLOAD)));
      end else if (pick < 85) begin
        b = 8'($urandom);
        if (b == ufp_pkg::SYNC_SECOND) b = ufp_pkg::SYNC_FIRST;
        queue_byte(ufp_pkg::SYNC_FIRST);
        queue_byte(b);
      end else if (pick < 92) begin
        add_cut_frame();
      end else begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end
      flush_bytes();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first sync byte repeated in place of the second, must not start a frame
    queue_byte(ufp_pkg::SYNC_FIRST);
    queue_byte(ufp_pkg::SYNC_FIRST);
    queue_byte(ufp_pkg::SYNC_SECOND);
    add_frame(ufp_pkg::CLASS_RXM, ufp_pkg::ID_RAWX, 0, DMG_NONE);
    add_frame(ufp_pkg::CLASS_RXM, ufp_pkg::ID_SFRBX, 1, DMG_NONE);
    add_frame(8'hFF, 8'h00, 0, DMG_CK_B);
    flush_bytes();

    run_phase(0, 0);
    add_frame(8'($urandom), 8'($urandom), 16'h0100, DMG_NONE);
    flush_bytes();
    run_phase(87, 0);
    run_phase(0, 87);
    run_phase(21, 21);

    valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ufp_pkg.sv
rtl/ubx_frame_parser_counter.sv
rtl/ufp_checker.sv
dv/ubx_frame_parser_counter_checker.sv
dv/tb_ubx_frame_parser_counter.sv
